### design/nsd_pkg.sv
package nsd_pkg;

    // Default sizes
    localparam int NSD_MAX_SEEDS  = 32;
    localparam int NSD_COORD_BITS = 12;

    // Fixed field widths
    localparam int IDX_FIELD_W = 5;
    localparam int COORD_W     = 12;
    localparam int COLOR_W     = 8;
    localparam int GRAY_W      = 8;
    localparam int WIDTH_W     = 12;
    localparam int COUNT_W     = 6;

    // Running limit and its square
    localparam int LIMIT_W = 14;
    localparam int LSQ_W   = 2 * LIMIT_W;
    localparam logic [LIMIT_W-1:0] START_LIMIT    = LIMIT_W'(9999);
    localparam logic [LSQ_W-1:0]   START_LIMIT_SQ = LSQ_W'(9999 * 9999);
    localparam logic [GRAY_W-1:0]  GRAY_MAX       = GRAY_W'(255);

    // Iterative units
    localparam int STEP_W     = 4;
    localparam int ROOT_STEPS = LSQ_W / 2;
    localparam int DIV_STEPS  = GRAY_W;
    localparam int NUM_W      = LIMIT_W + GRAY_W;

    // Function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register index (address bit 2)
    localparam logic REG_PIX_WIDTH  = 1'b0;
    localparam logic REG_SEED_COUNT = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    typedef struct packed {
        logic                   func;
        logic [IDX_FIELD_W-1:0] seed_index;
        logic [COORD_W-1:0]     x_coord;
        logic [COORD_W-1:0]     y_coord;
        logic [COLOR_W-1:0]     seed_color;
    } nsd_in_t;

    typedef struct packed {
        logic [GRAY_W-1:0]  gray_level;
        logic [COLOR_W-1:0] nearest_color;
    } nsd_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQR,
        ST_CMP,
        ST_ROOT,
        ST_UPDATE,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } nsd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic start;
        logic inc;
        logic cmp;
        logic root_step;
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
    } nsd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sel;
        logic last;
    } nsd_sts_t;

endpackage

### design/nsd_ram.sv
module nsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/nsd_datapath.sv
module nsd_datapath #(
    parameter int MAX_SEEDS  = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                            aclk,
    input  nsd_pkg::nsd_in_t                in_data,
    input  logic [nsd_pkg::WIDTH_W-1:0]     pix_width,
    input  logic [nsd_pkg::COUNT_W-1:0]     seed_count,
    input  nsd_pkg::nsd_cmd_t               cmd,
    output nsd_pkg::nsd_sts_t               sts,
    output nsd_pkg::nsd_out_t               out_data
);
    import nsd_pkg::*;

    localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int ENT_W = 2 * COORD_BITS + COLOR_W;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int D2_W  = SQ_W + 1;
    localparam int CMP_W = (D2_W > LSQ_W) ? D2_W : LSQ_W;
    localparam int N_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam logic [LSQ_W-1:0] ROOT_BIT_INIT = LSQ_W'(1) << (LSQ_W - 2);

    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [LIMIT_W-1:0]    m_reg;
    logic [LSQ_W-1:0]      msq_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [LSQ_W-1:0]      v_reg, res_reg, bit_reg, d2s_reg;
    logic [NUM_W-1:0]      num_reg, div_reg;
    logic [GRAY_W-1:0]     q_reg;
    logic                  sat_reg;
    nsd_out_t              out_reg;

    logic                  wr_en;
    logic [ENT_W-1:0]      wr_ent, rd_ent;
    logic [COORD_BITS-1:0] ent_x, ent_y;
    logic [COLOR_W-1:0]    ent_c;
    logic [COORD_BITS-1:0] dx, dy;
    logic [SQ_W-1:0]       sqx, sqy;
    logic [D2_W-1:0]       d2;
    logic [N_W-1:0]        n_eff, cnt_ext, max_ext;
    logic                  hit;
    logic [LSQ_W-1:0]      root_trial;
    logic [NUM_W-1:0]      num_init;

    // Seed table: loads write, scan reads at the running index
    assign wr_en  = cmd.load_wr && (N_W'(in_data.seed_index) < N_W'(MAX_SEEDS));
    assign wr_ent = {COORD_BITS'(in_data.x_coord), COORD_BITS'(in_data.y_coord),
                     in_data.seed_color};

    nsd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SEEDS)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (IDX_W'(in_data.seed_index)),
        .wdata (wr_ent),
        .raddr (idx_reg),
        .rdata (rd_ent)
    );

    assign ent_x = rd_ent[ENT_W-1 -: COORD_BITS];
    assign ent_y = rd_ent[COLOR_W +: COORD_BITS];
    assign ent_c = rd_ent[COLOR_W-1:0];

    // Distance terms
    assign dx  = (px_reg >= ent_x) ? px_reg - ent_x : ent_x - px_reg;
    assign dy  = (py_reg >= ent_y) ? py_reg - ent_y : ent_y - py_reg;
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign d2  = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign hit = CMP_W'(d2) < CMP_W'(msq_reg);

    // Effective seed count and scan end
    assign cnt_ext = N_W'(seed_count);
    assign max_ext = N_W'(MAX_SEEDS);
    assign n_eff   = (cnt_ext > max_ext) ? max_ext : cnt_ext;

    assign sts.sel  = hit && (seed_count != '0);
    assign sts.last = (N_W'(idx_reg) + N_W'(1)) >= n_eff;

    assign root_trial = res_reg + bit_reg;
    assign num_init   = (NUM_W'(m_reg) << GRAY_W) - NUM_W'(m_reg);

    always_ff @(posedge aclk) begin
        sqx_reg <= sqx;
        sqy_reg <= sqy;

        // New query
        if (cmd.start) begin
            px_reg  <= COORD_BITS'(in_data.x_coord);
            py_reg  <= COORD_BITS'(in_data.y_coord);
            idx_reg <= '0;
            m_reg   <= START_LIMIT;
            msq_reg <= START_LIMIT_SQ;
        end
        if (cmd.inc) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end

        // Compare; entry 0 color is the fallback
        if (cmd.cmp) begin
            if ((idx_reg == '0) || sts.sel) begin
                color_reg <= ent_c;
            end
            if (sts.sel) begin
                v_reg     <= LSQ_W'(d2);
                d2s_reg   <= LSQ_W'(d2);
                res_reg   <= '0;
                bit_reg   <= ROOT_BIT_INIT;
            end
        end

        // Square root, two bits per step
        if (cmd.root_step) begin
            if (v_reg >= root_trial) begin
                v_reg   <= v_reg - root_trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        // New limit; remainder gives root squared
        if (cmd.update) begin
            m_reg   <= LIMIT_W'(res_reg);
            msq_reg <= d2s_reg - v_reg;
        end

        // Gray scaling: restoring division, one quotient bit per step
        if (cmd.div_init) begin
            num_reg <= num_init;
            sat_reg <= num_init >= (NUM_W'(pix_width) << GRAY_W);
            div_reg <= NUM_W'(pix_width) << (GRAY_W - 1);
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (num_reg >= div_reg) begin
                num_reg <= num_reg - div_reg;
                q_reg   <= {q_reg[GRAY_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[GRAY_W-2:0], 1'b0};
            end
            div_reg <= div_reg >> 1;
        end

        // Output register
        if (cmd.out_load) begin
            out_reg.gray_level    <= sat_reg ? GRAY_MAX : q_reg;
            out_reg.nearest_color <= color_reg;
        end
    end

    assign out_data = out_reg;

endmodule

### design/nsd_ctrl.sv
module nsd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    output logic              m_valid,
    input  logic              m_ready,
    input  nsd_pkg::nsd_sts_t sts,
    output nsd_pkg::nsd_cmd_t cmd
);
    import nsd_pkg::*;

    nsd_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        // Result leaves on transfer
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SQR;
            end
            ST_SQR: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
                if (sts.sel) begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end else if (sts.last) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    cmd.inc    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (sts.last) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    cmd.inc    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

### design/nearest_seed_distance_shader.sv
// Load transfer: no result; the next item can follow in the next cycle.
// Query: the result follows the scan of n entries (at least one), with k seeds
// selected (each runs the 14-step square root), then the 8-step divider; the next
// input can be taken in the cycle the result turns valid. A result still waiting
// holds the next query in its last state. One item is worked on at a time.
// Reset (aresetn low, synchronous) idles the controller, drops m_valid, restores the
module nearest_seed_distance_shader #(
    parameter int MAX_SEEDS  = nsd_pkg::NSD_MAX_SEEDS,
    parameter int COORD_BITS = nsd_pkg::NSD_COORD_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input items
    input  logic              s_valid,
    output logic              s_ready,
    input  nsd_pkg::nsd_in_t  s_data,
    // Results
    output logic              m_valid,
    input  logic              m_ready,
    output nsd_pkg::nsd_out_t m_data
);
    // register defaults (width 512, seed count 1) and keeps the seed table contents.
    import nsd_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               cfg_wr;
    nsd_cmd_t           cmd;
    nsd_sts_t           sts;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            count_reg <= COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PIX_WIDTH:  width_reg <= pwdata[WIDTH_W-1:0];
                REG_SEED_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (paddr[2])
            REG_PIX_WIDTH:  prdata = 32'(width_reg);
            REG_SEED_COUNT: prdata = 32'(count_reg);
            default:        prdata = '0;
        endcase
    end

    nsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nsd_datapath #(
        .MAX_SEEDS  (MAX_SEEDS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .in_data    (s_data),
        .pix_width  (width_reg),
        .seed_count (count_reg),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (m_data)
    );

endmodule
